[hw/rtl/ewau_pkg.sv]
// Shared types, codes and the action decision for the wear-aware byte store.
// No dependencies; used by eeprom_wear_aware_update and its checker.
package ewau_pkg;

  localparam int          ByteW       = 8;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;

  // Request kinds
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_ERASE  = 2'd1;
  localparam logic [1:0] FUNC_AND    = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // Cell actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_BOTH  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] new_byte;
    logic [1:0]       action;
  } decide_t;

  // Pick the cheapest action that turns old_byte into the requested byte
  function automatic decide_t decide(input logic [1:0] func,
                                     input logic [ByteW-1:0] old_byte,
                                     input logic [ByteW-1:0] value,
                                     input logic split);
    decide_t    res;
    logic [1:0] kind;
    res.new_byte = old_byte;
    res.action   = ACT_NONE;
    kind         = func;
    // An update to the erased value is an erase
    if (func == FUNC_UPDATE && value == ERASED_BYTE) begin
      kind = FUNC_ERASE;
    end
    unique case (kind)
      FUNC_UPDATE: begin
        res.new_byte = value;
        if (value != old_byte) begin
          res.action = (split && ((value & old_byte) == value)) ? ACT_WRITE : ACT_BOTH;
        end
      end
      FUNC_ERASE: begin
        res.new_byte = ERASED_BYTE;
        if (old_byte != ERASED_BYTE) begin
          res.action = split ? ACT_ERASE : ACT_BOTH;
        end
      end
      FUNC_AND: begin
        res.new_byte = old_byte & value;
        if ((old_byte & value) != old_byte) begin
          res.action = split ? ACT_WRITE : ACT_BOTH;
        end
      end
      FUNC_READ: begin
        res.new_byte = old_byte;
        res.action   = ACT_NONE;
      end
      default: begin
        res.new_byte = old_byte;
        res.action   = ACT_NONE;
      end
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/ewau_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
module ewau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[hw/rtl/eeprom_wear_aware_update.sv]
// Wear-aware byte store: top level. Depends on ewau_pkg and ewau_ram.
//
// Usage:
//   Request channel: an item (in_func, in_address, in_value) transfers at a
//   rising edge where start is high and busy is low. Every request gives
//   exactly one result.
//   Result channel: out_strobe is high for one cycle with out_performed,
//   out_action, out_old_byte and out_new_byte. The receiver cannot stall; the
//   result is taken at the edge ending that cycle.
//   Config channel: cfg_split_erase_write transfers when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Pipeline: the request is held in stage s1 while its cell is read, and the
//   result is registered from s1. Throughput: one request per cycle while
//   busy is low; the cell RAM is read at accept and written in the following
//   cycle; a one-entry forward register covers a back-to-back same-address request.
// Reset: synchronous, active low. After reset the block sweeps the cell RAM
//   writing 0xFF, one entry a cycle; busy is high during the sweep. Split mode
//   resets to 1. Addresses wrap modulo STORE_DEPTH when it is >= 64 or a power of 2.
module eeprom_wear_aware_update
  import ewau_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [9:0] in_address,
  input  logic [7:0] in_value,
  output logic       out_strobe,
  output logic       out_performed,
  output logic [1:0] out_action,
  output logic [7:0] out_old_byte,
  output logic [7:0] out_new_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_split_erase_write
);

  localparam int AddrW       = 10;
  localparam int IdxW        = $clog2(STORE_DEPTH);
  localparam int MaxAddr     = (1 << AddrW) - 1;
  localparam int ReduceSteps = 4;  // address < 16 * minimum depth

  // Control registers
  logic            clearing_r, clearing_nxt;
  logic [IdxW-1:0] clr_idx_r, clr_idx_nxt;
  logic            split_r, split_nxt;
  logic            s1_valid_r;
  logic            fwd_valid_r;
  logic            out_strobe_r;

  // Payload registers
  logic [1:0]      s1_func_r;
  logic [IdxW-1:0] s1_idx_r;
  logic [7:0]      s1_value_r;
  logic [IdxW-1:0] fwd_idx_r;
  logic [7:0]      fwd_byte_r;
  logic            out_performed_r;
  logic [1:0]      out_action_r;
  logic [7:0]      out_old_byte_r;
  logic [7:0]      out_new_byte_r;

  logic             accept;
  logic [AddrW-1:0] addr_wrap;
  logic [IdxW-1:0]  in_idx;
  logic [7:0]       ram_rdata;
  logic [7:0]       old_byte;
  decide_t          dec;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [7:0]       ram_wdata;

  assign busy      = clearing_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Wrap the address modulo STORE_DEPTH by restoring subtraction
  always_comb begin
    addr_wrap = in_address;
    for (int k = ReduceSteps - 1; k >= 0; k--) begin
      if ((STORE_DEPTH << k) <= MaxAddr) begin
        if (addr_wrap >= AddrW'(STORE_DEPTH << k)) begin
          addr_wrap = addr_wrap - AddrW'(STORE_DEPTH << k);
        end
      end
    end
  end

  assign in_idx = IdxW'(addr_wrap);

  // Clearing sweep after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      if (clr_idx_r == IdxW'(STORE_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  // Split mode register
  always_comb begin
    split_nxt = split_r;
    if (cfg_valid && cfg_ready) begin
      split_nxt = cfg_split_erase_write;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_idx_r    <= '0;
      split_r      <= 1'b1;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      clearing_r   <= clearing_nxt;
      clr_idx_r    <= clr_idx_nxt;
      split_r      <= split_nxt;
      s1_valid_r   <= accept;
      fwd_valid_r  <= s1_valid_r;
      out_strobe_r <= s1_valid_r;
    end
  end

  // Hold the request while its cell is read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r  <= in_func;
      s1_idx_r   <= in_idx;
      s1_value_r <= in_value;
    end
  end

  // Cell RAM
  ewau_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_cells (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr   (in_idx),
    .rdata_r (ram_rdata)
  );

  // Forward the byte written last cycle; the RAM read then saw the old contents
  assign old_byte = (fwd_valid_r && fwd_idx_r == s1_idx_r) ? fwd_byte_r : ram_rdata;
  assign dec      = decide(s1_func_r, old_byte, s1_value_r, split_r);

  // Write back the new byte, or erase during the sweep
  assign ram_we    = clearing_r || s1_valid_r;
  assign ram_waddr = clearing_r ? clr_idx_r : s1_idx_r;
  assign ram_wdata = clearing_r ? ERASED_BYTE : dec.new_byte;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      fwd_idx_r       <= s1_idx_r;
      fwd_byte_r      <= dec.new_byte;
      out_performed_r <= (dec.action != ACT_NONE);
      out_action_r    <= dec.action;
      out_old_byte_r  <= old_byte;
      out_new_byte_r  <= dec.new_byte;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_performed = out_performed_r;
  assign out_action    = out_action_r;
  assign out_old_byte  = out_old_byte_r;
  assign out_new_byte  = out_new_byte_r;

endmodule

[hw/rtl/ewau_check.sv]
// Port-level checker for eeprom_wear_aware_update, bound to the top level.
// Depends on ewau_pkg for the action codes.
module ewau_check
  import ewau_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_performed,
  input logic [1:0] out_action,
  input logic [7:0] out_old_byte,
  input logic [7:0] out_new_byte
);

  // Every accepted request is followed by its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("request transfer without result");

  // No result without an earlier accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without request");

  // performed flags exactly the actions that touch the cell
  a_performed: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_performed == (out_action != ACT_NONE)))
    else $error("performed does not match action");

  // No action leaves the byte unchanged
  a_none_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_action == ACT_NONE) |-> (out_new_byte == out_old_byte))
    else $error("byte changed without action");

  // A write alone can only clear bits, an erase alone only sets them all
  a_single_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_action == ACT_WRITE || out_action == ACT_ERASE)) |->
      (out_action == ACT_WRITE ? ((out_new_byte & ~out_old_byte) == 8'h00)
                               : (out_new_byte == ERASED_BYTE)))
    else $error("single operation with impossible result");

endmodule

bind eeprom_wear_aware_update ewau_check u_ewau_check (.*);
